// ----- rtl/core/irpd_pkg.sv -----
// Shared types and constants for the IR pulse-distance transceiver.
package irpd_pkg;

    localparam int TX_WORD_W = 9;
    localparam int RX_WORD_W = 16;
    localparam int RX_CNT_W  = 5;

    // Request opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Configuration register indexes (byte address is 4 * index).
    typedef enum logic [2:0] {
        REG_MS_DIVIDER = 3'd0,
        REG_START_LEN  = 3'd1,
        REG_ZERO_LEN   = 3'd2,
        REG_ONE_LEN    = 3'd3,
        REG_GAP_LEN    = 3'd4,
        REG_STOP_LEN   = 3'd5
    } t_reg_idx;

    // Receiver bit counter stops here.
    localparam logic [RX_CNT_W-1:0] RX_COUNT_MAX = 5'd16;

    // Receiver gap thresholds, in coarse time steps.
    localparam logic [7:0] GAP_START    = 8'd5;
    localparam logic [7:0] GAP_ONE_MIN  = 8'd2;
    localparam logic [7:0] GAP_DATA_MAX = 8'd4;

    typedef struct packed {
        logic [7:0]  ms_divider;
        logic [15:0] start_len;
        logic [7:0]  zero_len;
        logic [7:0]  one_len;
        logic [7:0]  gap_len;
        logic [15:0] stop_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] coarse_time;
        logic       carrier_next;
        logic       index_in_range;
    } t_tx_stat;

    typedef struct packed {
        logic [RX_WORD_W-1:0] shift_next;
        logic                 valid_next;
        logic [RX_CNT_W-1:0]  bit_count;
    } t_rx_stat;

endpackage

// ----- rtl/core/irpd_in_if.sv -----
// Input request channel: carrier tick or receiver edge, plus the next word to send.
interface irpd_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [irpd_pkg::TX_WORD_W-1:0] tx_word;

    modport source(output valid, op, tx_word, input ready);
    modport sink(input valid, op, tx_word, output ready);
endinterface

// ----- rtl/core/irpd_out_if.sv -----
// Result channel: carrier enable, receiver word and word-complete flag.
interface irpd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           carrier_on;
    logic [irpd_pkg::RX_WORD_W-1:0] rx_word;
    logic                           rx_valid;

    modport source(output valid, carrier_on, rx_word, rx_valid, input ready);
    modport sink(input valid, carrier_on, rx_word, rx_valid, output ready);
endinterface

// ----- rtl/core/ir_pulse_distance_transceiver.sv -----
// IR pulse-distance transceiver top level.
// Requests are held in an input register, results in an output register.
// Throughput: one request per cycle; while a result waits for its sink the
// input register takes one more request, then input ready drops.
// Reset (synchronous, active low) clears codec state and result valid, and
// loads the configuration registers with their default values.
module ir_pulse_distance_transceiver #(
    parameter int FRAME_BITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irpd_in_if.sink     i_in,
    irpd_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    irpd_pkg::t_cfg     cfg;
    irpd_pkg::t_tx_stat tx_stat;
    irpd_pkg::t_rx_stat rx_stat;

    logic                           r_in_valid;
    logic                           r_op;
    logic [irpd_pkg::TX_WORD_W-1:0] r_tx_word;
    logic                           r_out_valid;
    logic                           r_carrier_on;
    logic [irpd_pkg::RX_WORD_W-1:0] r_rx_word;
    logic                           r_rx_valid;
    logic                           advance;
    logic                           in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    irpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irpd_tx #(.FRAME_BITS(FRAME_BITS)) u_tx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (advance && (r_op == irpd_pkg::OP_TICK)),
        .i_tx_word (r_tx_word),
        .i_cfg     (cfg),
        .o_stat    (tx_stat)
    );

    irpd_rx #(.FRAME_BITS(FRAME_BITS)) u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_edge        (advance && (r_op == irpd_pkg::OP_EDGE)),
        .i_coarse_time (tx_stat.coarse_time),
        .o_stat        (rx_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_op      <= i_in.op;
            r_tx_word <= i_in.tx_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_carrier_on <= tx_stat.carrier_next;
            r_rx_word    <= rx_stat.shift_next;
            r_rx_valid   <= rx_stat.valid_next;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.carrier_on = r_carrier_on;
    assign o_out.rx_word    = r_rx_word;
    assign o_out.rx_valid   = r_rx_valid;

    a_tx_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_stat.index_in_range)
        else $error("tx bit index out of frame range");

    a_rx_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_stat.bit_count <= irpd_pkg::RX_COUNT_MAX)
        else $error("rx bit count past saturation");

    a_tick_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_op == irpd_pkg::OP_TICK) |=> !r_rx_valid)
        else $error("word flagged on a tick request");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_in_valid && r_out_valid)
        else $error("input stalled without a pending request");
endmodule

// ----- rtl/core/irpd_regs.sv -----
// APB configuration register file.
module irpd_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output irpd_pkg::t_cfg      o_cfg
);
    irpd_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ms_divider <= 8'd38;
            r_cfg.start_len  <= 16'd190;
            r_cfg.zero_len   <= 8'd38;
            r_cfg.one_len    <= 8'd114;
            r_cfg.gap_len    <= 8'd76;
            r_cfg.stop_len   <= 16'd950;
        end else if (wr_en) begin
            unique case (reg_idx)
                irpd_pkg::REG_MS_DIVIDER: r_cfg.ms_divider <= pwdata[7:0];
                irpd_pkg::REG_START_LEN:  r_cfg.start_len  <= pwdata[15:0];
                irpd_pkg::REG_ZERO_LEN:   r_cfg.zero_len   <= pwdata[7:0];
                irpd_pkg::REG_ONE_LEN:    r_cfg.one_len    <= pwdata[7:0];
                irpd_pkg::REG_GAP_LEN:    r_cfg.gap_len    <= pwdata[7:0];
                irpd_pkg::REG_STOP_LEN:   r_cfg.stop_len   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            irpd_pkg::REG_MS_DIVIDER: prdata = {24'd0, r_cfg.ms_divider};
            irpd_pkg::REG_START_LEN:  prdata = {16'd0, r_cfg.start_len};
            irpd_pkg::REG_ZERO_LEN:   prdata = {24'd0, r_cfg.zero_len};
            irpd_pkg::REG_ONE_LEN:    prdata = {24'd0, r_cfg.one_len};
            irpd_pkg::REG_GAP_LEN:    prdata = {24'd0, r_cfg.gap_len};
            irpd_pkg::REG_STOP_LEN:   prdata = {16'd0, r_cfg.stop_len};
            default:                  prdata = 32'd0;
        endcase
    end
endmodule

// ----- rtl/core/irpd_tx.sv -----
// Transmitter: tick prescaler, coarse time and frame phase sequencer.
module irpd_tx #(
    parameter int FRAME_BITS = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick,
    input  logic [irpd_pkg::TX_WORD_W-1:0] i_tx_word,
    input  irpd_pkg::t_cfg                 i_cfg,
    output irpd_pkg::t_tx_stat             o_stat
);
    localparam int IW = $clog2(FRAME_BITS + 2) + 1;
    localparam logic signed [IW-1:0] IDX_LAST  = IW'(FRAME_BITS);
    localparam logic signed [IW-1:0] IDX_RESET = -IW'(2);

    logic [7:0]                     r_prescale, n_prescale;
    logic [7:0]                     r_coarse, n_coarse;
    logic [15:0]                    r_phase_count, n_phase_count;
    logic [15:0]                    r_phase_len, n_phase_len;
    logic                           r_mark_done, n_mark_done;
    logic signed [IW-1:0]           r_bit_index, n_bit_index;
    logic [irpd_pkg::TX_WORD_W-1:0] r_tx_shift, n_tx_shift;
    logic                           r_carrier, n_carrier;

    logic signed [IW-1:0] idx_inc;
    logic [15:0]          shift16;
    logic [3:0]           bit_sel;
    logic [7:0]           prescale_inc;
    logic [15:0]          count_inc;

    assign idx_inc      = r_bit_index + IW'(1);
    assign shift16      = {{(16 - irpd_pkg::TX_WORD_W){1'b0}}, r_tx_shift};
    assign bit_sel      = 4'(unsigned'(idx_inc));
    assign prescale_inc = r_prescale + 8'd1;
    assign count_inc    = r_phase_count + 16'd1;

    always_comb begin
        n_prescale    = r_prescale;
        n_coarse      = r_coarse;
        n_phase_count = r_phase_count;
        n_phase_len   = r_phase_len;
        n_mark_done   = r_mark_done;
        n_bit_index   = r_bit_index;
        n_tx_shift    = r_tx_shift;
        n_carrier     = r_carrier;
        if (i_tick) begin
            n_prescale = prescale_inc;
            if (prescale_inc >= i_cfg.ms_divider) begin
                n_coarse   = r_coarse + 8'd1;
                n_prescale = 8'd0;
            end
            n_phase_count = count_inc;
            if (count_inc > r_phase_len) begin
                if (r_mark_done) begin
                    n_phase_len = {8'd0, i_cfg.gap_len};
                    n_carrier   = 1'b0;
                end else begin
                    n_bit_index = idx_inc;
                    priority if (idx_inc < 0) begin
                        n_phase_len = i_cfg.start_len;
                        n_carrier   = 1'b1;
                    end else if (idx_inc < IDX_LAST) begin
                        n_phase_len = shift16[bit_sel] ? {8'd0, i_cfg.one_len}
                                                       : {8'd0, i_cfg.zero_len};
                        n_carrier   = 1'b1;
                    end else if (idx_inc == IDX_LAST) begin
                        n_phase_len = i_cfg.stop_len;
                    end else begin
                        // frame over: back to idle slot before the start mark
                        n_bit_index = IDX_RESET;
                        n_tx_shift  = i_tx_word;
                    end
                end
                n_mark_done   = !r_mark_done;
                n_phase_count = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale    <= 8'd0;
            r_coarse      <= 8'd0;
            r_phase_count <= 16'd0;
            r_phase_len   <= 16'd0;
            r_mark_done   <= 1'b0;
            r_bit_index   <= IDX_RESET;
            r_tx_shift    <= '0;
            r_carrier     <= 1'b0;
        end else begin
            r_prescale    <= n_prescale;
            r_coarse      <= n_coarse;
            r_phase_count <= n_phase_count;
            r_phase_len   <= n_phase_len;
            r_mark_done   <= n_mark_done;
            r_bit_index   <= n_bit_index;
            r_tx_shift    <= n_tx_shift;
            r_carrier     <= n_carrier;
        end
    end

    assign o_stat.coarse_time    = r_coarse;
    assign o_stat.carrier_next   = n_carrier;
    assign o_stat.index_in_range = (r_bit_index >= IDX_RESET) && (r_bit_index <= IDX_LAST);
endmodule

// ----- rtl/core/irpd_rx.sv -----
// Receiver: edge gap measurement, start detection and bit shifter.
module irpd_rx #(
    parameter int FRAME_BITS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_edge,
    input  logic [7:0]         i_coarse_time,
    output irpd_pkg::t_rx_stat o_stat
);
    logic [7:0]                          r_last, n_last;
    logic                                r_started, n_started;
    logic                                r_data_phase, n_data_phase;
    logic [irpd_pkg::RX_CNT_W-1:0]       r_count, n_count;
    logic [irpd_pkg::RX_WORD_W-1:0]      r_shift, n_shift;
    logic [7:0]                          gap;

    assign gap = i_coarse_time - r_last;

    always_comb begin
        n_last       = r_last;
        n_started    = r_started;
        n_data_phase = r_data_phase;
        n_count      = r_count;
        n_shift      = r_shift;
        if (i_edge) begin
            if (gap == irpd_pkg::GAP_START) begin
                n_started = 1'b1;
            end else if (gap > irpd_pkg::GAP_START) begin
                n_started = 1'b0;
                n_count   = '0;
            end
            // bits land on every other edge; gaps of 4 or more carry none
            if (n_started && r_data_phase && (n_count < irpd_pkg::RX_COUNT_MAX)
                && (gap < irpd_pkg::GAP_DATA_MAX)) begin
                n_shift[n_count[3:0]] = (gap >= irpd_pkg::GAP_ONE_MIN);
                n_count = n_count + 5'd1;
            end
            n_data_phase = !r_data_phase;
            n_last       = i_coarse_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= 8'd0;
            r_started    <= 1'b0;
            r_data_phase <= 1'b0;
            r_count      <= '0;
            r_shift      <= '0;
        end else begin
            r_last       <= n_last;
            r_started    <= n_started;
            r_data_phase <= n_data_phase;
            r_count      <= n_count;
            r_shift      <= n_shift;
        end
    end

    assign o_stat.shift_next = n_shift;
    assign o_stat.valid_next = i_edge && (n_count == irpd_pkg::RX_CNT_W'(FRAME_BITS));
    assign o_stat.bit_count  = r_count;
endmodule
